[src/msp_pkg.sv]
// shared constants, types and helpers for the minblep saw/pulse oscillator
`default_nettype none

package msp_pkg;

    // sizes of the correction machinery
    localparam int RING_DEPTH      = 48;
    localparam int CORRECTION_TAPS = 47;
    localparam int OVERSAMPLE      = 32;
    localparam int TABLE_DEPTH     = 1505;

    // derived widths
    localparam int RING_AW  = $clog2(RING_DEPTH);
    localparam int TABLE_AW = $clog2(TABLE_DEPTH);
    localparam int TAP_CW   = $clog2(CORRECTION_TAPS);
    localparam int OS_SHIFT = $clog2(OVERSAMPLE);
    localparam int CT_W     = 16;
    localparam int DIV_CW   = $clog2(CT_W);
    localparam int K_W      = TABLE_AW + 1;

    // field widths
    localparam int INC_W    = 31;
    localparam int PHASE_W  = 32;
    localparam int SAMPLE_W = 32;
    localparam int WORD_W   = 24;

    // input item commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // configuration register indexes
    localparam logic CFG_PHASE_INC = 1'b0;
    localparam logic CFG_WAVE_MODE = 1'b1;

    // reset values and fixed-point constants
    localparam logic [INC_W-1:0] INC_RESET = 31'd429496730;
    localparam logic signed [33:0] ONE_Q24 = 34'sd16777216;
    localparam logic signed [26:0] ONE_Q22 = 27'sd4194304;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_TAP_A,
        S_TAP_B,
        S_TAP_MUL,
        S_TAP_WR,
        S_OUT_RD,
        S_OUT_SUM,
        S_OUT_FIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic tick;
        logic load;
        logic div_step;
        logic tap_a;
        logic tap_b;
        logic tap_mul;
        logic tap_wr;
        logic out_sum;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic wrap;
        logic div_last;
        logic tap_last;
        logic out_free;
    } t_status;

    // clamp to the signed 32-bit range
    function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [33:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/msp_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module msp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/msp_ctrl.sv]
// sequencer for tick, division, correction taps and output
`default_nettype none

module msp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_cmd,
    output logic                  o_in_ready,
    input  wire msp_pkg::t_status i_status,
    output msp_pkg::t_cmd         o_ctl
);

    msp_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            msp_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_cmd == msp_pkg::CMD_LOAD) begin
                        o_ctl.load = 1'b1;
                    end else begin
                        o_ctl.tick = 1'b1;
                        n_state = i_status.wrap ? msp_pkg::S_DIV : msp_pkg::S_OUT_RD;
                    end
                end
            end
            msp_pkg::S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = msp_pkg::S_TAP_A;
                end
            end
            msp_pkg::S_TAP_A: begin
                o_ctl.tap_a = 1'b1;
                n_state = msp_pkg::S_TAP_B;
            end
            msp_pkg::S_TAP_B: begin
                o_ctl.tap_b = 1'b1;
                n_state = msp_pkg::S_TAP_MUL;
            end
            msp_pkg::S_TAP_MUL: begin
                o_ctl.tap_mul = 1'b1;
                n_state = msp_pkg::S_TAP_WR;
            end
            msp_pkg::S_TAP_WR: begin
                o_ctl.tap_wr = 1'b1;
                n_state = i_status.tap_last ? msp_pkg::S_OUT_RD : msp_pkg::S_TAP_A;
            end
            msp_pkg::S_OUT_RD: begin
                n_state = msp_pkg::S_OUT_SUM;
            end
            msp_pkg::S_OUT_SUM: begin
                o_ctl.out_sum = 1'b1;
                n_state = msp_pkg::S_OUT_FIN;
            end
            msp_pkg::S_OUT_FIN: begin
                if (i_status.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state = msp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = msp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/msp_datapath.sv]
// phase accumulator, serial divider, step table, correction ring and output register
`default_nettype none

module msp_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_index,
    input  wire logic [msp_pkg::INC_W-1:0]           i_cfg_wdata,
    input  wire logic [msp_pkg::TABLE_AW-1:0]        i_table_addr,
    input  wire logic signed [msp_pkg::WORD_W-1:0]   i_table_word,
    input  wire logic                                i_out_ready,
    input  wire msp_pkg::t_cmd                       i_ctl,
    output msp_pkg::t_status                         o_status,
    output logic                                     o_out_valid,
    output logic signed [msp_pkg::SAMPLE_W-1:0]      o_sample_out
);

    localparam int RA = msp_pkg::RING_AW;
    localparam int KW = msp_pkg::K_W;
    localparam int CW = msp_pkg::CT_W;
    localparam int OS = msp_pkg::OS_SHIFT;

    // configuration
    logic [msp_pkg::INC_W-1:0] r_inc;
    logic                      r_mode;

    // control state
    logic [msp_pkg::PHASE_W-1:0] r_phase;
    logic [RA-1:0]               r_pos;
    logic [RA-1:0]               r_slot;
    logic                        r_pol;
    logic                        r_neg;
    logic [msp_pkg::DIV_CW-1:0]  r_div_cnt;
    logic [msp_pkg::TAP_CW-1:0]  r_tap;
    logic [msp_pkg::RING_DEPTH-1:0] r_vld;

    // payload registers
    logic [msp_pkg::INC_W-1:0]   r_rem;
    logic [CW-1:0]               r_quot;
    logic [KW-1:0]               r_k;
    logic signed [msp_pkg::WORD_W-1:0]   r_a;
    logic signed [msp_pkg::SAMPLE_W-1:0] r_ring;
    logic signed [41:0]                  r_prod;
    logic signed [msp_pkg::SAMPLE_W-1:0] r_entry;

    // memory ports
    logic [msp_pkg::WORD_W-1:0]   w_tab_rdata;
    logic [msp_pkg::TABLE_AW-1:0] w_tab_raddr;
    logic                         w_tab_we;
    logic [msp_pkg::SAMPLE_W-1:0] w_ring_rdata;
    logic [RA-1:0]                w_ring_raddr;
    logic signed [msp_pkg::SAMPLE_W-1:0] w_ring_wdata;

    // phase sum and wrap
    logic [msp_pkg::PHASE_W:0] w_sum;
    assign w_sum = {1'b0, r_phase} + {2'b0, r_inc};

    logic [RA-1:0] w_pos_inc, w_slot_inc;
    assign w_pos_inc  = (r_pos == RA'(msp_pkg::RING_DEPTH - 1)) ? '0 : r_pos + 1'b1;
    assign w_slot_inc = (r_slot == RA'(msp_pkg::RING_DEPTH - 1)) ? '0 : r_slot + 1'b1;

    // restoring divider step
    logic [msp_pkg::INC_W:0] w_rem2, w_rem_sub;
    logic                    w_ge;
    logic [CW-1:0]           w_quot_n;
    assign w_rem2    = {r_rem, 1'b0};
    assign w_ge      = w_rem2 >= {1'b0, r_inc};
    assign w_rem_sub = w_rem2 - {1'b0, r_inc};
    assign w_quot_n  = {r_quot[CW-2:0], w_ge};

    // table indexes and interpolation fraction
    logic [KW-1:0] w_k1;
    logic          w_k_ok, w_k1_ok;
    logic [CW-1:0] w_frac;
    assign w_k1    = r_k + 1'b1;
    assign w_k_ok  = r_k < KW'(msp_pkg::TABLE_DEPTH);
    assign w_k1_ok = w_k1 < KW'(msp_pkg::TABLE_DEPTH);
    assign w_frac  = {r_quot[CW-OS-1:0], {OS{1'b0}}};
    assign w_tab_raddr = i_ctl.tap_a ? r_k[msp_pkg::TABLE_AW-1:0]
                                     : w_k1[msp_pkg::TABLE_AW-1:0];
    assign w_tab_we = i_ctl.load && (i_table_addr < msp_pkg::TABLE_AW'(msp_pkg::TABLE_DEPTH));

    // interpolation product
    logic signed [msp_pkg::WORD_W-1:0] w_b;
    logic signed [msp_pkg::WORD_W:0]   w_diff;
    assign w_b    = w_k1_ok ? $signed(w_tab_rdata) : '0;
    assign w_diff = {w_b[msp_pkg::WORD_W-1], w_b} - {r_a[msp_pkg::WORD_W-1], r_a};

    // correction word and saturating ring add
    logic signed [41:0] w_sh;
    logic signed [26:0] w_v, w_m;
    logic signed [33:0] w_corr, w_tap_sum;
    assign w_sh   = r_prod >>> 16;
    assign w_v    = 27'(r_a) + w_sh[26:0];
    assign w_m    = msp_pkg::ONE_Q22 - w_v;
    assign w_corr = r_neg ? -(34'(w_m) <<< (r_mode ? 3 : 2)) : (34'(w_m) <<< (r_mode ? 3 : 2));
    assign w_tap_sum = 34'(r_ring) + w_corr;
    assign w_ring_wdata = msp_pkg::sat32(w_tap_sum);
    assign w_ring_raddr = i_ctl.tap_a ? r_slot : r_pos;

    // naive waveform and output entry
    logic signed [33:0] w_d, w_naive, w_out_sum, w_saw;
    logic signed [msp_pkg::SAMPLE_W-1:0] w_ring_val;
    assign w_d       = $signed({2'b0, r_phase}) - $signed({3'b0, r_inc});
    assign w_naive   = r_mode ? (r_pol ? msp_pkg::ONE_Q24 : -msp_pkg::ONE_Q24) : (w_d >>> 8);
    assign w_ring_val = r_vld[r_pos] ? $signed(w_ring_rdata) : '0;
    assign w_out_sum = 34'(w_ring_val) + w_naive;
    assign w_saw     = {r_entry[msp_pkg::SAMPLE_W-1], r_entry, 1'b0} - msp_pkg::ONE_Q24;

    // status
    assign o_status.wrap     = w_sum[msp_pkg::PHASE_W];
    assign o_status.div_last = r_div_cnt == msp_pkg::DIV_CW'(CW - 1);
    assign o_status.tap_last = r_tap == msp_pkg::TAP_CW'(msp_pkg::CORRECTION_TAPS - 1);
    assign o_status.out_free = !o_out_valid || i_out_ready;

    msp_ram #(.WIDTH(msp_pkg::WORD_W), .DEPTH(msp_pkg::TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_waddr (i_table_addr),
        .i_wdata (i_table_word),
        .i_raddr (w_tab_raddr),
        .o_rdata (w_tab_rdata)
    );

    msp_ram #(.WIDTH(msp_pkg::SAMPLE_W), .DEPTH(msp_pkg::RING_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_ctl.tap_wr),
        .i_waddr (r_slot),
        .i_wdata (w_ring_wdata),
        .i_raddr (w_ring_raddr),
        .o_rdata (w_ring_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc       <= msp_pkg::INC_RESET;
            r_mode      <= 1'b0;
            r_phase     <= '0;
            r_pos       <= '0;
            r_slot      <= '0;
            r_pol       <= 1'b0;
            r_neg       <= 1'b0;
            r_div_cnt   <= '0;
            r_tap       <= '0;
            r_vld       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == msp_pkg::CFG_PHASE_INC) begin
                    r_inc <= i_cfg_wdata;
                end else begin
                    r_mode <= i_cfg_wdata[0];
                end
            end
            if (i_ctl.tick) begin
                r_phase   <= w_sum[msp_pkg::PHASE_W-1:0];
                r_pos     <= w_pos_inc;
                r_div_cnt <= '0;
                r_neg     <= r_mode && !r_pol;
                if (o_status.wrap && r_mode) begin
                    r_pol <= !r_pol;
                end
            end
            if (i_ctl.div_step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
                if (o_status.div_last) begin
                    r_slot <= r_pos;
                    r_tap  <= '0;
                end
            end
            if (i_ctl.tap_wr) begin
                r_vld[r_slot] <= 1'b1;
                r_slot <= w_slot_inc;
                r_tap  <= r_tap + 1'b1;
            end
            if (i_ctl.out_sum) begin
                r_vld[r_pos] <= 1'b0;
            end
            if (i_ctl.out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.tick) begin
            r_rem  <= w_sum[msp_pkg::INC_W-1:0];
            r_quot <= '0;
        end
        if (i_ctl.div_step) begin
            r_rem  <= w_ge ? w_rem_sub[msp_pkg::INC_W-1:0] : w_rem2[msp_pkg::INC_W-1:0];
            r_quot <= w_quot_n;
            if (o_status.div_last) begin
                r_k <= KW'(w_quot_n[CW-1 -: OS]);
            end
        end
        if (i_ctl.tap_b) begin
            r_a    <= w_k_ok ? $signed(w_tab_rdata) : '0;
            r_ring <= r_vld[r_slot] ? $signed(w_ring_rdata) : '0;
        end
        if (i_ctl.tap_mul) begin
            r_prod <= 42'(w_diff) * 42'($signed({1'b0, w_frac}));
        end
        if (i_ctl.tap_wr) begin
            r_k <= r_k + KW'(msp_pkg::OVERSAMPLE);
        end
        if (i_ctl.out_sum) begin
            r_entry <= msp_pkg::sat32(w_out_sum);
        end
        if (i_ctl.out_load) begin
            o_sample_out <= r_mode ? r_entry : msp_pkg::sat32(w_saw);
        end
    end

endmodule

`default_nettype wire

[src/minblep_saw_pulse_oscillator.sv]
// top level of the minblep band-limited saw/pulse oscillator
// A load item writes one step table word and returns no result.
// A tick item returns one sample. When the phase does not wrap, the tick goes through
// the output read, sum and finish states to the output register. When it wraps, the
// 16-step serial divider first finds the crossing time, then each of the 47 correction
// taps makes two step table reads on the single table read port, followed by a ring
// read-modify-write, before the output states. The input is not taken while a tick is
// in progress; a finished sample sits in the output register while the next item is
// taken. The ring clears through per-entry valid bits at reset, so no clearing pass is needed.
`default_nettype none

module minblep_saw_pulse_oscillator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_index,
    input  wire logic [msp_pkg::INC_W-1:0]           i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_cmd,
    input  wire logic [msp_pkg::TABLE_AW-1:0]        i_table_addr,
    input  wire logic signed [msp_pkg::WORD_W-1:0]   i_table_word,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [msp_pkg::SAMPLE_W-1:0]      o_sample_out
);

    msp_pkg::t_cmd    w_ctl;
    msp_pkg::t_status w_status;

    // sequencer
    msp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_ctl      (w_ctl)
    );

    // arithmetic and storage
    msp_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_table_addr (i_table_addr),
        .i_table_word (i_table_word),
        .i_out_ready  (i_out_ready),
        .i_ctl        (w_ctl),
        .o_status     (w_status),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out)
    );

endmodule

`default_nettype wire

[src/msp_checker.sv]
// port-level checks for the oscillator, bound to the top level
`default_nettype none

module msp_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_ready,
    input wire logic                           i_cmd,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [msp_pkg::SAMPLE_W-1:0]   o_sample_out
);

    // a waiting sample holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_out))
        else $error("output sample dropped or changed while stalled");

    // a tick transfer keeps the block busy for the following cycle
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_cmd == msp_pkg::CMD_TICK |=> !o_in_ready)
        else $error("input taken right after a tick");

    // a load transfer never creates a sample
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_cmd == msp_pkg::CMD_LOAD && !o_out_valid
        |=> !o_out_valid)
        else $error("sample appeared after a table load");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind minblep_saw_pulse_oscillator msp_checker u_msp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_cmd        (i_cmd),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sample_out (o_sample_out)
);

`default_nettype wire
